[hdl/ogrc_pkg.sv]
// ----------------------------------------------------------------------------
// ogrc_pkg
// types, codes and helpers shared by the occupancy grid ray caster
// ----------------------------------------------------------------------------
package ogrc_pkg;

	localparam int DIV_NW = 50;
	localparam int DIV_DW = 20;

	localparam logic [2:0] CFG_ROBOT_X    = 3'd0;
	localparam logic [2:0] CFG_ROBOT_Y    = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd2;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd3;
	localparam logic [2:0] CFG_RESOLUTION = 3'd4;

	localparam logic KIND_CAST = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] CELL_UNKNOWN = 8'hFF;
	localparam logic [7:0] CELL_FREE    = 8'h00;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [15:0] intensity;
		logic [7:0]         read_col;
		logic [7:0]         read_row;
	} in_t;

	typedef struct packed {
		logic signed [7:0] cell_value;
		logic [10:0]       cells_written;
		logic              blocked;
		logic              too_long;
	} out_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
		logic [DIV_DW-1:0] rem;
	} div_out_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_SQ1, S_SQ2, S_SQRT, S_STL, S_STW, S_POS,
		S_PXL, S_PXW, S_PYL, S_PYW, S_CXL, S_CXW, S_CYL, S_CYW,
		S_MAP, S_CHK, S_RCELL, S_RCW, S_DONE
	} state_t;

	function automatic logic [7:0] remap(input logic signed [15:0] raw);
		logic [16:0] a;
		a = raw[15] ? 17'(-{raw[15], raw}) : 17'({1'b0, raw});
		if (a == 17'd0) a = 17'd100;
		if (a > 17'd255) a = 17'd255;
		if (a == 17'd127 || a == 17'd128) a = 17'd129;
		return 8'(a - 17'd128);
	endfunction

endpackage

[hdl/ogrc_ram.sv]
// ----------------------------------------------------------------------------
// ogrc_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module ogrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hdl/ogrc_div.sv]
// ----------------------------------------------------------------------------
// ogrc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ogrc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ogrc_pkg::DIV_NW-1:0]    num,
	input  logic [ogrc_pkg::DIV_DW-1:0]    den,
	output ogrc_pkg::div_out_t             res
);

	localparam int NW = ogrc_pkg::DIV_NW;
	localparam int DW = ogrc_pkg::DIV_DW;
	localparam int CNTW = $clog2(NW);

	logic [NW-1:0]   num_q;
	logic [NW-1:0]   quot_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic            fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			quot_q <= {quot_q[NW-2:0], fits};
			rem_q  <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

[hdl/occupancy_grid_ray_cast.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_ray_cast
// 2d occupancy grid held in one ram, rays cast by a sequencer
// ----------------------------------------------------------------------------
// read transaction: S_RCELL addresses the cell, S_RCW captures it, then done strobes;
// an off-map read goes straight to done. cast transaction: a square root and a
// divide give the step count; each sample takes four divides (two on the last), a
// ram read and a write, then a one-cycle done; one transaction at a time, results
// never stall. after reset the grid is swept to unknown, one cell a cycle, over all
// GRID_W*GRID_H cells with busy high; configuration writes are taken at any time
module occupancy_grid_ray_cast #(
	parameter int GRID_W     = 256,
	parameter int GRID_H     = 256,
	parameter int MAX_STEPS  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ogrc_pkg::in_t      cmd,
	output logic               done,
	output ogrc_pkg::out_t     result,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int CELLS = GRID_W * GRID_H;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(MAX_STEPS + 1);
	localparam int CW    = $clog2(GRID_W);
	localparam int RW    = $clog2(GRID_H);
	localparam int NW    = ogrc_pkg::DIV_NW;
	localparam int DW    = ogrc_pkg::DIV_DW;

	ogrc_pkg::state_t state_q, state_d;

	logic signed [31:0] robot_x_q, robot_y_q, origin_x_q, origin_y_q;
	logic [19:0]        res_q;
	logic [19:0]        res_eff;

	ogrc_pkg::in_t      cmd_q;
	logic [AW-1:0]      clr_q;
	logic signed [32:0] dx_q, dy_q;
	logic [32:0]        mdx, mdy;
	logic [65:0]        dist_q, sqd_q;
	logic [34:0]        sqrem_q, sqrem2, sqtrial;
	logic [32:0]        sqroot_q;
	logic [5:0]         iter_q;
	logic [33:0]        ceil_root;
	logic [SW-1:0]      steps_q, k_q;
	logic [NW:0]        steps_full;
	logic [NW-1:0]      prodx_q, prody_q;
	logic signed [33:0] sx_q, sy_q;
	logic signed [34:0] diffx, diffy;
	logic [34:0]        mdiffx, mdiffy;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic               col_ok_q, row_ok_q;
	logic [AW-1:0]      addr_q, addr_new, addr_rd;
	logic [10:0]        written_q;
	logic               blocked_q, too_long_q;
	logic [7:0]         cellv_q;
	logic               last;
	logic               occupied;
	logic               read_in_map;

	logic               div_start;
	logic [NW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	ogrc_pkg::div_out_t div_res;

	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [7:0]         ram_wdata, ram_rdata;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q  <= 32'sd0;
			robot_y_q  <= 32'sd0;
			origin_x_q <= -32'sd655360;
			origin_y_q <= -32'sd655360;
			res_q      <= 20'd6554;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogrc_pkg::CFG_ROBOT_X:    robot_x_q  <= cfg_data;
				ogrc_pkg::CFG_ROBOT_Y:    robot_y_q  <= cfg_data;
				ogrc_pkg::CFG_ORIGIN_X:   origin_x_q <= cfg_data;
				ogrc_pkg::CFG_ORIGIN_Y:   origin_y_q <= cfg_data;
				ogrc_pkg::CFG_RESOLUTION: res_q      <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign res_eff = (res_q == 20'd0) ? 20'd1 : res_q;

	// datapath helpers
	assign mdx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign mdy = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

	assign sqrem2    = {sqrem_q[32:0], sqd_q[65:64]};
	assign sqtrial   = {sqroot_q[32:0], 2'b01};
	assign ceil_root = {1'b0, sqroot_q} + {33'd0, (sqrem_q != 35'd0)};
	assign steps_full = {1'b0, div_res.quot} + {NW'(0), (div_res.rem != '0)};

	assign diffx  = {sx_q[33], sx_q} - {{3{origin_x_q[31]}}, origin_x_q};
	assign diffy  = {sy_q[33], sy_q} - {{3{origin_y_q[31]}}, origin_y_q};
	assign mdiffx = diffx[34] ? 35'(-diffx) : 35'(diffx);
	assign mdiffy = diffy[34] ? 35'(-diffy) : 35'(diffy);

	assign last     = (k_q == steps_q);
	assign addr_new = AW'(row_q * GRID_W) + AW'(col_q);
	assign addr_rd  = AW'(cmd_q.read_row * GRID_W) + AW'(cmd_q.read_col);
	assign occupied = (ram_rdata != ogrc_pkg::CELL_UNKNOWN) && (ram_rdata != ogrc_pkg::CELL_FREE);
	assign read_in_map = (int'(cmd.read_col) < GRID_W) && (int'(cmd.read_row) < GRID_H);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ogrc_pkg::S_CLEAR: if (clr_q == AW'(CELLS - 1)) state_d = ogrc_pkg::S_IDLE;
			ogrc_pkg::S_IDLE: begin
				if (start) begin
					if (cmd.kind == ogrc_pkg::KIND_CAST) state_d = ogrc_pkg::S_SQ1;
					else if (read_in_map) state_d = ogrc_pkg::S_RCELL;
					else state_d = ogrc_pkg::S_DONE;
				end
			end
			ogrc_pkg::S_SQ1:  state_d = ogrc_pkg::S_SQ2;
			ogrc_pkg::S_SQ2:  state_d = ogrc_pkg::S_SQRT;
			ogrc_pkg::S_SQRT: if (iter_q == 6'd32) state_d = ogrc_pkg::S_STL;
			ogrc_pkg::S_STL:  state_d = ogrc_pkg::S_STW;
			ogrc_pkg::S_STW: begin
				if (div_res.done) begin
					if (steps_full > (NW + 1)'(MAX_STEPS)) state_d = ogrc_pkg::S_DONE;
					else state_d = ogrc_pkg::S_POS;
				end
			end
			ogrc_pkg::S_POS:  state_d = last ? ogrc_pkg::S_CXL : ogrc_pkg::S_PXL;
			ogrc_pkg::S_PXL:  state_d = ogrc_pkg::S_PXW;
			ogrc_pkg::S_PXW:  if (div_res.done) state_d = ogrc_pkg::S_PYL;
			ogrc_pkg::S_PYL:  state_d = ogrc_pkg::S_PYW;
			ogrc_pkg::S_PYW:  if (div_res.done) state_d = ogrc_pkg::S_CXL;
			ogrc_pkg::S_CXL:  state_d = ogrc_pkg::S_CXW;
			ogrc_pkg::S_CXW:  if (div_res.done) state_d = ogrc_pkg::S_CYL;
			ogrc_pkg::S_CYL:  state_d = ogrc_pkg::S_CYW;
			ogrc_pkg::S_CYW:  if (div_res.done) state_d = ogrc_pkg::S_MAP;
			ogrc_pkg::S_MAP: begin
				if (col_ok_q && row_ok_q) state_d = ogrc_pkg::S_CHK;
				else state_d = last ? ogrc_pkg::S_DONE : ogrc_pkg::S_POS;
			end
			ogrc_pkg::S_CHK: begin
				if (occupied || last) state_d = ogrc_pkg::S_DONE;
				else state_d = ogrc_pkg::S_POS;
			end
			ogrc_pkg::S_RCELL: state_d = ogrc_pkg::S_RCW;
			ogrc_pkg::S_RCW:   state_d = ogrc_pkg::S_DONE;
			ogrc_pkg::S_DONE:  state_d = ogrc_pkg::S_IDLE;
			default:           state_d = ogrc_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy      = (state_q != ogrc_pkg::S_IDLE);
		done      = (state_q == ogrc_pkg::S_DONE);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = res_eff;
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = ogrc_pkg::CELL_FREE;
		unique case (state_q)
			ogrc_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = ogrc_pkg::CELL_UNKNOWN;
			end
			ogrc_pkg::S_STL: begin
				div_start = 1'b1;
				div_num   = NW'(ceil_root);
			end
			ogrc_pkg::S_PXL: begin
				div_start = 1'b1;
				div_num   = prodx_q;
				div_den   = DW'(steps_q);
			end
			ogrc_pkg::S_PYL: begin
				div_start = 1'b1;
				div_num   = prody_q;
				div_den   = DW'(steps_q);
			end
			ogrc_pkg::S_CXL: begin
				div_start = 1'b1;
				div_num   = NW'(mdiffx);
			end
			ogrc_pkg::S_CYL: begin
				div_start = 1'b1;
				div_num   = NW'(mdiffy);
			end
			ogrc_pkg::S_MAP:   ram_addr = addr_new;
			ogrc_pkg::S_RCELL: ram_addr = addr_rd;
			ogrc_pkg::S_CHK: begin
				ram_we    = !occupied;
				ram_wdata = last ? ogrc_pkg::remap(cmd_q.intensity) : ogrc_pkg::CELL_FREE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogrc_pkg::S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ogrc_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ogrc_pkg::S_IDLE: begin
				cmd_q      <= cmd;
				dx_q       <= {cmd.point_x[31], cmd.point_x} - {robot_x_q[31], robot_x_q};
				dy_q       <= {cmd.point_y[31], cmd.point_y} - {robot_y_q[31], robot_y_q};
				written_q  <= '0;
				blocked_q  <= 1'b0;
				too_long_q <= 1'b0;
				cellv_q    <= (cmd.kind == ogrc_pkg::KIND_CAST) ? 8'd0 : ogrc_pkg::CELL_UNKNOWN;
			end
			ogrc_pkg::S_SQ1: dist_q <= 66'(mdx) * 66'(mdx);
			ogrc_pkg::S_SQ2: begin
				sqd_q    <= dist_q + 66'(mdy) * 66'(mdy);
				sqrem_q  <= '0;
				sqroot_q <= '0;
				iter_q   <= '0;
			end
			ogrc_pkg::S_SQRT: begin
				sqd_q  <= {sqd_q[63:0], 2'b00};
				iter_q <= iter_q + 1'b1;
				if (sqrem2 >= sqtrial) begin
					sqrem_q  <= sqrem2 - sqtrial;
					sqroot_q <= {sqroot_q[31:0], 1'b1};
				end else begin
					sqrem_q  <= sqrem2;
					sqroot_q <= {sqroot_q[31:0], 1'b0};
				end
			end
			ogrc_pkg::S_STW: begin
				if (div_res.done) begin
					steps_q    <= SW'(steps_full);
					k_q        <= '0;
					too_long_q <= steps_full > (NW + 1)'(MAX_STEPS);
				end
			end
			ogrc_pkg::S_POS: begin
				prodx_q <= NW'(mdx) * NW'(k_q);
				prody_q <= NW'(mdy) * NW'(k_q);
				sx_q    <= {{2{cmd_q.point_x[31]}}, cmd_q.point_x};
				sy_q    <= {{2{cmd_q.point_y[31]}}, cmd_q.point_y};
			end
			ogrc_pkg::S_PXW: begin
				if (div_res.done) begin
					sx_q <= {{2{robot_x_q[31]}}, robot_x_q}
						+ (dx_q[32] ? -34'(div_res.quot) : 34'(div_res.quot));
				end
			end
			ogrc_pkg::S_PYW: begin
				if (div_res.done) begin
					sy_q <= {{2{robot_y_q[31]}}, robot_y_q}
						+ (dy_q[32] ? -34'(div_res.quot) : 34'(div_res.quot));
				end
			end
			ogrc_pkg::S_CXW: begin
				if (div_res.done) begin
					col_q    <= div_res.quot[CW-1:0];
					col_ok_q <= (!diffx[34] || div_res.quot == '0)
						&& (div_res.quot < NW'(GRID_W));
				end
			end
			ogrc_pkg::S_CYW: begin
				if (div_res.done) begin
					row_q    <= div_res.quot[RW-1:0];
					row_ok_q <= (!diffy[34] || div_res.quot == '0)
						&& (div_res.quot < NW'(GRID_H));
				end
			end
			ogrc_pkg::S_MAP: begin
				addr_q <= addr_new;
				if (!(col_ok_q && row_ok_q) && !last) k_q <= k_q + 1'b1;
			end
			ogrc_pkg::S_CHK: begin
				if (occupied) begin
					blocked_q <= 1'b1;
				end else begin
					written_q <= written_q + 1'b1;
					if (!last) k_q <= k_q + 1'b1;
				end
			end
			ogrc_pkg::S_RCW: cellv_q <= ram_rdata;
			default: ;
		endcase
	end

	assign result.cell_value    = cellv_q;
	assign result.cells_written = written_q;
	assign result.blocked       = blocked_q;
	assign result.too_long      = too_long_q;

	ogrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	ogrc_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_too_long_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.too_long |-> result.cells_written == 11'd0 && !result.blocked)
		else $error("rejected ray reports grid activity");

	a_no_div_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_start) else $error("divider restarted while running");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ram_we) else $error("grid written while idle");
`endif

endmodule
